// ===== src/obb_overlap_separating_axis_top_assert.svh =====
// Assertion macros for the box overlap block
`ifndef OBB_OVERLAP_SEPARATING_AXIS_TOP_ASSERT_SVH
`define OBB_OVERLAP_SEPARATING_AXIS_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define OBB_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("obb assertion failed");
`define OBB_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("obb assertion failed");
`else
`define OBB_ASSERT(name, clk, rst_n, prop)
`define OBB_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

// ===== src/obbsat_pkg.sv =====
`default_nettype none
package obbsat_pkg;

    // external request / response
    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [31:0] vec_x;
        logic signed [31:0] vec_y;
        logic signed [31:0] vec_z;
        logic [30:0]        half_length;
    } t_req;

    typedef struct packed {
        logic       overlap;
        logic [3:0] separating_axis;
    } t_rsp;

    // internal fixed-point word
    typedef logic signed [63:0] t_fx;
    localparam t_fx FX_MAX = {1'b0, {63{1'b1}}};
    localparam t_fx FX_MIN = {1'b1, {63{1'b0}}};

    // register file map
    localparam logic [5:0] AD_CEN  = 6'd0;
    localparam logic [5:0] AD_AX   = 6'd6;
    localparam logic [5:0] AD_EXT  = 6'd24;
    localparam logic [5:0] AD_SA   = 6'd30;
    localparam logic [5:0] AD_SB   = 6'd39;
    localparam logic [5:0] AD_D    = 6'd48;
    localparam logic [5:0] AD_C    = 6'd51;
    localparam logic [5:0] AD_ZERO = 6'd63;

    localparam logic [4:0] PRE_LAST  = 5'd20;
    localparam logic [3:0] AXIS_LAST = 4'd14;
    localparam logic [3:0] AXIS_NONE = 4'd15;

    // classified load request passed from front to back
    typedef struct packed {
        logic        trig;
        logic        centre;
        logic [5:0]  vaddr;
        logic [5:0]  eaddr;
        t_fx         v0;
        t_fx         v1;
        t_fx         v2;
        logic [30:0] hl;
    } t_load;

    typedef enum logic [3:0] {
        OP_MUL0, OP_MULA, OP_MULS, OP_MULW, OP_WR,
        OP_SUB, OP_LABS, OP_RLD, OP_RADD, OP_TEST
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [5:0] ra;
        logic [5:0] rb;
        logic [5:0] dst;
    } t_instr;

    function automatic t_fx sat_add(t_fx a, t_fx b);
        t_fx s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63]) begin
            s = a[63] ? FX_MIN : FX_MAX;
        end
        return s;
    endfunction

    function automatic t_fx sat_neg(t_fx a);
        return (a == FX_MIN) ? FX_MAX : -a;
    endfunction

    function automatic t_fx sat_abs(t_fx a);
        return a[63] ? sat_neg(a) : a;
    endfunction

    // microcode: preamble, then per axis step sequences
    function automatic t_instr gen_instr(logic pre, logic [3:0] ax, logic [4:0] st);
        t_instr     ins;
        logic [4:0] x;
        logic [5:0] g;
        logic [1:0] k;
        logic [5:0] n;
        logic [5:0] s;
        logic [5:0] base;
        logic [3:0] c4;
        logic [1:0] i;
        logic [1:0] j;
        logic [5:0] p;
        logic [5:0] q;
        ins.op  = OP_RLD;
        ins.ra  = AD_ZERO;
        ins.rb  = AD_ZERO;
        ins.dst = AD_ZERO;
        x = '0;
        g = '0;
        k = '0;
        n = '0;
        s = '0;
        base = '0;
        c4 = '0;
        i = '0;
        j = '0;
        p = '0;
        q = '0;
        if (pre) begin
            // distance vector, then scaled axes
            if (st < 5'd3) begin
                ins.op  = OP_SUB;
                ins.ra  = AD_CEN + 6'(st);
                ins.rb  = AD_CEN + 6'd3 + 6'(st);
                ins.dst = AD_D + 6'(st);
            end else begin
                x = st - 5'd3;
                if (x >= 5'd15)      g = 6'd5;
                else if (x >= 5'd12) g = 6'd4;
                else if (x >= 5'd9)  g = 6'd3;
                else if (x >= 5'd6)  g = 6'd2;
                else if (x >= 5'd3)  g = 6'd1;
                else                 g = 6'd0;
                ins.op  = OP_MULW;
                ins.ra  = AD_AX + 6'(x);
                ins.rb  = AD_EXT + g;
                ins.dst = AD_SA + 6'(x);
            end
        end else if (ax < 4'd6) begin
            // face axis of A or B
            n = AD_AX + 6'(ax) * 6'd3;
            s = (ax < 4'd3) ? AD_SB : AD_SA;
            if (st < 5'd3) begin
                ins.op = (st == 5'd0) ? OP_MUL0 : OP_MULA;
                ins.ra = AD_D + 6'(st);
                ins.rb = n + 6'(st);
            end else if (st == 5'd3) begin
                ins.op = OP_LABS;
            end else if (st == 5'd4) begin
                ins.op = OP_RLD;
                ins.ra = AD_EXT + 6'(ax);
            end else if (st < 5'd17) begin
                x = st - 5'd5;
                g = 6'(x[4:2]);
                k = x[1:0];
                if (k == 2'd3) begin
                    ins.op = OP_RADD;
                end else begin
                    ins.op = (k == 2'd0) ? OP_MUL0 : OP_MULA;
                    ins.ra = n + 6'(k);
                    ins.rb = s + g * 6'd3 + 6'(k);
                end
            end else begin
                ins.op = OP_TEST;
            end
        end else begin
            // cross axis Ai x Bj
            c4 = ax - 4'd6;
            if (c4 >= 4'd6)      i = 2'd2;
            else if (c4 >= 4'd3) i = 2'd1;
            else                 i = 2'd0;
            j = 2'(c4 - 4'(i) * 4'd3);
            p = AD_AX + 6'(i) * 6'd3;
            q = AD_AX + 6'd9 + 6'(j) * 6'd3;
            if (st < 5'd9) begin
                unique case (st)
                    5'd0: begin ins.op = OP_MUL0; ins.ra = p + 6'd1; ins.rb = q + 6'd2; end
                    5'd1: begin ins.op = OP_MULS; ins.ra = p + 6'd2; ins.rb = q + 6'd1; end
                    5'd2: begin ins.op = OP_WR;   ins.dst = AD_C; end
                    5'd3: begin ins.op = OP_MUL0; ins.ra = p + 6'd2; ins.rb = q; end
                    5'd4: begin ins.op = OP_MULS; ins.ra = p; ins.rb = q + 6'd2; end
                    5'd5: begin ins.op = OP_WR;   ins.dst = AD_C + 6'd1; end
                    5'd6: begin ins.op = OP_MUL0; ins.ra = p; ins.rb = q + 6'd1; end
                    5'd7: begin ins.op = OP_MULS; ins.ra = p + 6'd1; ins.rb = q; end
                    default: begin ins.op = OP_WR; ins.dst = AD_C + 6'd2; end
                endcase
            end else if (st == 5'd9) begin
                ins.op = OP_RLD;
                ins.ra = AD_ZERO;
            end else if (st < 5'd26) begin
                x = st - 5'd10;
                k = x[1:0];
                unique case (x[3:2])
                    2'd0:    base = AD_SA + ((i == 2'd0) ? 6'd3 : 6'd0);
                    2'd1:    base = AD_SA + ((i == 2'd2) ? 6'd3 : 6'd6);
                    2'd2:    base = AD_SB + ((j == 2'd0) ? 6'd3 : 6'd0);
                    default: base = AD_SB + ((j == 2'd2) ? 6'd3 : 6'd6);
                endcase
                if (k == 2'd3) begin
                    ins.op = OP_RADD;
                end else begin
                    ins.op = (k == 2'd0) ? OP_MUL0 : OP_MULA;
                    ins.ra = AD_C + 6'(k);
                    ins.rb = base + 6'(k);
                end
            end else if (st < 5'd29) begin
                x = st - 5'd26;
                ins.op = (x == 5'd0) ? OP_MUL0 : OP_MULA;
                ins.ra = AD_D + 6'(x);
                ins.rb = AD_C + 6'(x);
            end else if (st == 5'd29) begin
                ins.op = OP_LABS;
            end else begin
                ins.op = OP_TEST;
            end
        end
        return ins;
    endfunction

endpackage
`default_nettype wire

// ===== src/obbsat_front.sv =====
`default_nettype none
module obbsat_front #(
    parameter int COORD_WIDTH = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire obbsat_pkg::t_req  i_req,
    output logic                   o_q_valid,
    output obbsat_pkg::t_load      o_q_item,
    input  wire logic              i_q_pop
);
    import obbsat_pkg::*;

    localparam bit SEXT_EN  = (COORD_WIDTH <= 32);
    localparam int SIGN_IDX = (COORD_WIDTH <= 32) ? COORD_WIDTH - 1 : 31;

    t_load      r_q [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    t_load      w_item;
    logic       w_push;
    logic [5:0] w_a;

    // take the low COORD_WIDTH bits as two's complement
    function automatic t_fx sext(logic [31:0] v);
        t_fx r;
        for (int b = 0; b < 64; b++) begin
            if (b < COORD_WIDTH && b < 32) r[b] = v[b];
            else if (b < COORD_WIDTH)       r[b] = 1'b0;
            else                            r[b] = SEXT_EN ? v[SIGN_IDX] : 1'b0;
        end
        return r;
    endfunction

    // classify the request into store addresses
    always_comb begin
        w_a = (i_req.cmd[2] ? 6'd3 : 6'd0) + 6'(i_req.cmd[1:0]) - 6'd1;
        w_item.trig   = (i_req.cmd == 3'd7);
        w_item.centre = (i_req.cmd[1:0] == 2'd0);
        w_item.vaddr  = w_item.centre ? (i_req.cmd[2] ? AD_CEN + 6'd3 : AD_CEN)
                                      : AD_AX + w_a + (w_a << 1);
        w_item.eaddr  = AD_EXT + w_a;
        w_item.v0     = sext(i_req.vec_x);
        w_item.v1     = sext(i_req.vec_y);
        w_item.v2     = sext(i_req.vec_z);
        w_item.hl     = i_req.half_length;
    end

    assign o_stall   = (r_cnt == 2'd2);
    assign w_push    = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_q[r_rd];

    // two-entry queue
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= w_item;
        end
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wr <= !r_wr;
            if (i_q_pop) r_rd <= !r_rd;
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_q_pop);
        end
    end
endmodule
`default_nettype wire

// ===== src/obbsat_back.sv =====
`default_nettype none
`include "obb_overlap_separating_axis_top_assert.svh"
module obbsat_back #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_q_valid,
    input  wire obbsat_pkg::t_load i_q_item,
    output logic                   o_q_pop,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output obbsat_pkg::t_rsp       o_out_rsp
);
    import obbsat_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_LOAD  = 7'b0000010,
        S_FETCH = 7'b0000100,
        S_EXEC  = 7'b0001000,
        S_MUL   = 7'b0010000,
        S_MFIN  = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    t_load  r_ld, n_ld;
    logic [1:0] r_lc, n_lc;
    logic   r_pre, n_pre;
    logic [3:0] r_ax, n_ax;
    logic [4:0] r_st, n_st;
    t_fx    r_acc, n_acc;
    t_fx    r_l, n_l;
    t_fx    r_r, n_r;
    logic [63:0]  r_ua, n_ua;
    logic [63:0]  r_ub, n_ub;
    logic         r_neg, n_neg;
    logic [127:0] r_prod, n_prod;
    logic [1:0]   r_pp, n_pp;
    logic [3:0]   r_res, n_res;
    logic         r_out_valid, n_out_valid;
    t_rsp         r_out, n_out;

    // register file with two registered read ports
    t_fx          r_rf [64];
    logic [63:0]  r_vld;
    t_fx          r_rda, r_rdb;
    logic         r_va, r_vb;
    logic         w_en;
    logic [5:0]   w_addr;
    t_fx          w_data;

    t_instr       ins;
    t_fx          opa, opb;
    logic [31:0]  pa, pb;
    logic [63:0]  ppv;
    logic [127:0] ppx;
    logic [127:0] q128;
    logic         msat;
    t_fx          mval;
    logic [4:0]   adv_st;
    logic         adv_pre;
    logic         sep;

    assign ins = gen_instr(r_pre, r_ax, r_st);
    assign opa = r_va ? r_rda : '0;
    assign opb = r_vb ? r_rdb : '0;

    // one 32x32 partial product per cycle
    assign pa   = r_pp[0] ? r_ua[63:32] : r_ua[31:0];
    assign pb   = r_pp[1] ? r_ub[63:32] : r_ub[31:0];
    assign ppv  = 64'(pa) * 64'(pb);
    assign ppx  = {64'b0, ppv} << {({1'b0, r_pp[0]} + {1'b0, r_pp[1]}), 5'b0};

    // truncate magnitude and saturate
    assign q128 = r_prod >> FRAC_BITS;
    assign msat = |q128[127:63];
    assign mval = r_neg ? (msat ? FX_MIN : -t_fx'(q128[63:0]))
                        : (msat ? FX_MAX : t_fx'(q128[63:0]));

    assign adv_pre = r_pre && (r_st != PRE_LAST);
    assign adv_st  = (r_pre && r_st == PRE_LAST) ? 5'd0 : r_st + 5'd1;
    assign sep     = (r_l > r_r);

    always_comb begin
        n_state = r_state;
        n_ld    = r_ld;
        n_lc    = r_lc;
        n_pre   = r_pre;
        n_ax    = r_ax;
        n_st    = r_st;
        n_acc   = r_acc;
        n_l     = r_l;
        n_r     = r_r;
        n_ua    = r_ua;
        n_ub    = r_ub;
        n_neg   = r_neg;
        n_prod  = r_prod;
        n_pp    = r_pp;
        n_res   = r_res;
        n_out   = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        o_q_pop = 1'b0;
        w_en    = 1'b0;
        w_addr  = r_ld.vaddr;
        w_data  = r_ld.v0;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_ld    = i_q_item;
                    n_lc    = 2'd0;
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                // write vector words, then the extent of an axis load
                unique case (r_lc)
                    2'd0: begin w_en = 1'b1; w_addr = r_ld.vaddr; w_data = r_ld.v0; end
                    2'd1: begin w_en = 1'b1; w_addr = r_ld.vaddr + 6'd1; w_data = r_ld.v1; end
                    2'd2: begin w_en = 1'b1; w_addr = r_ld.vaddr + 6'd2; w_data = r_ld.v2; end
                    default: begin
                        w_en   = !r_ld.centre;
                        w_addr = r_ld.eaddr;
                        w_data = t_fx'({33'b0, r_ld.hl});
                    end
                endcase
                n_lc = r_lc + 2'd1;
                if (r_lc == 2'd3) begin
                    n_pre   = 1'b1;
                    n_ax    = 4'd0;
                    n_st    = 5'd0;
                    n_state = r_ld.trig ? S_FETCH : S_IDLE;
                end
            end
            S_FETCH: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                n_pre   = adv_pre;
                n_st    = adv_st;
                n_state = S_FETCH;
                unique case (ins.op)
                    OP_MUL0, OP_MULA, OP_MULS, OP_MULW: begin
                        n_pre   = r_pre;
                        n_st    = r_st;
                        n_ua    = opa[63] ? 64'(-opa) : 64'(opa);
                        n_ub    = opb[63] ? 64'(-opb) : 64'(opb);
                        n_neg   = opa[63] ^ opb[63];
                        n_prod  = '0;
                        n_pp    = 2'd0;
                        n_state = S_MUL;
                    end
                    OP_WR: begin
                        w_en = 1'b1; w_addr = ins.dst; w_data = r_acc;
                    end
                    OP_SUB: begin
                        w_en = 1'b1; w_addr = ins.dst; w_data = sat_add(opa, sat_neg(opb));
                    end
                    OP_LABS: n_l = sat_abs(r_acc);
                    OP_RLD:  n_r = opa;
                    OP_RADD: n_r = sat_add(r_r, sat_abs(r_acc));
                    default: begin
                        // axis test: stop on separation or after the last axis
                        n_st = 5'd0;
                        n_ax = r_ax + 4'd1;
                        if (sep) begin
                            n_res   = r_ax;
                            n_state = S_DONE;
                        end else if (r_ax == AXIS_LAST) begin
                            n_res   = AXIS_NONE;
                            n_state = S_DONE;
                        end
                    end
                endcase
            end
            S_MUL: begin
                n_prod = r_prod + ppx;
                n_pp   = r_pp + 2'd1;
                if (r_pp == 2'd3) n_state = S_MFIN;
            end
            S_MFIN: begin
                n_pre   = adv_pre;
                n_st    = adv_st;
                n_state = S_FETCH;
                unique case (ins.op)
                    OP_MUL0: n_acc = mval;
                    OP_MULA: n_acc = sat_add(r_acc, mval);
                    OP_MULS: n_acc = sat_add(r_acc, sat_neg(mval));
                    default: begin
                        w_en = 1'b1; w_addr = ins.dst; w_data = mval;
                    end
                endcase
            end
            default: begin
                // hold the result until the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid           = 1'b1;
                    n_out.overlap         = (r_res == AXIS_NONE);
                    n_out.separating_axis = r_res;
                    n_state               = S_IDLE;
                end
            end
        endcase
    end

    // register file storage
    always_ff @(posedge i_clk) begin
        if (w_en) r_rf[w_addr] <= w_data;
        r_rda <= r_rf[ins.ra];
        r_rdb <= r_rf[ins.rb];
        r_va  <= r_vld[ins.ra];
        r_vb  <= r_vld[ins.rb];
    end

    // control and datapath registers
    always_ff @(posedge i_clk) begin
        r_ld   <= n_ld;
        r_acc  <= n_acc;
        r_l    <= n_l;
        r_r    <= n_r;
        r_ua   <= n_ua;
        r_ub   <= n_ub;
        r_neg  <= n_neg;
        r_prod <= n_prod;
        r_res  <= n_res;
        r_out  <= n_out;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_lc        <= 2'd0;
            r_pre       <= 1'b0;
            r_ax        <= 4'd0;
            r_st        <= 5'd0;
            r_pp        <= 2'd0;
            r_out_valid <= 1'b0;
            r_vld       <= '0;
        end else begin
            r_state     <= n_state;
            r_lc        <= n_lc;
            r_pre       <= n_pre;
            r_ax        <= n_ax;
            r_st        <= n_st;
            r_pp        <= n_pp;
            r_out_valid <= n_out_valid;
            if (w_en) r_vld[w_addr] <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;

    `OBB_ASSERT(a_pop_idle, i_clk, i_rst_n, o_q_pop |-> r_state == S_IDLE)
    `OBB_ASSERT(a_pp_in_mul, i_clk, i_rst_n, r_pp != 2'd0 |-> r_state == S_MUL)
    `OBB_ASSERT(a_sep_done, i_clk, i_rst_n, (r_state == S_EXEC && ins.op == OP_TEST && sep) |=> (r_state == S_DONE && r_res != AXIS_NONE))
endmodule
`default_nettype wire

// ===== src/obb_overlap_separating_axis_top.sv =====
// Load requests: accepted into a two-entry queue, then stored word by word into the register file.
// Trigger request (cmd 7): after its store, the 15-axis test runs on one shared
// 64x64 multiplier built from four 32x32 partial products; the test stops early on a separation.
// Loads of the next pair queue up while the test runs; one result register on the output.
// Reset: synchronous, active low; clears control and all stores read back as zero.
`default_nettype none
module obb_overlap_separating_axis_top #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire obbsat_pkg::t_req i_in_req,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output obbsat_pkg::t_rsp      o_out_rsp
);
    import obbsat_pkg::*;

    logic  q_valid;
    t_load q_item;
    logic  q_pop;

    obbsat_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_stall   (o_in_stall),
        .i_req     (i_in_req),
        .o_q_valid (q_valid),
        .o_q_item  (q_item),
        .i_q_pop   (q_pop)
    );

    obbsat_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_rsp   (o_out_rsp)
    );
endmodule
`default_nettype wire
